@@ rtl/score_grid_min_max_splat_top_defines.svh @@
// ----------------------------------------------------------------------------
// Score grid assertion macros
// Shared assertion helpers for the score grid. Define NO_ASSERTIONS to drop
// every check from the build.
// ----------------------------------------------------------------------------
`ifndef SCORE_GRID_MIN_MAX_SPLAT_TOP_DEFINES_SVH
`define SCORE_GRID_MIN_MAX_SPLAT_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on the block clock, off during reset.
`define SG_ASSERT_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, sampled on the block clock, off during reset.
`define SG_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SG_ASSERT_IMPLY(name, ante, cons, msg)
`define SG_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

@@ rtl/sgrid_pkg.sv @@
// ----------------------------------------------------------------------------
// Score grid package
// Field layout, request and register codes, controller states and small
// helper functions of the score grid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sgrid_pkg;

   // Default grid size.
   localparam int DefGridCols = 128;
   localparam int DefGridRows = 128;

   // Field widths.
   localparam int ValW     = 16;
   localparam int CoordW   = 7;
   localparam int PosW     = 21;
   localparam int ScaleW   = 24;
   localparam int UsedW    = 8;
   localparam int DiffW    = PosW + 1;
   localparam int ProdW    = DiffW + ScaleW;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 24;
   localparam int ReqTypeW = 3;
   localparam int NbIdxW   = 4;

   // Request data layout, lowest bit first.
   localparam int CellXLsb  = 0;
   localparam int CellYLsb  = CellXLsb + CoordW;
   localparam int PosXLsb   = CellYLsb + CoordW;
   localparam int PosYLsb   = PosXLsb + PosW;
   localparam int NewValLsb = PosYLsb + PosW;
   localparam int ReqDataBits = NewValLsb + ValW;
   localparam int ReqTdataW = ((ReqDataBits + 7) / 8) * 8;

   // Cell value that marks an empty cell.
   localparam logic signed [ValW-1:0] InvalidMark = -16'sd1;

   // Number of cells touched by a plain update and by a full 3x3 splat.
   localparam logic [NbIdxW-1:0] NbOne = 4'd1;
   localparam logic [NbIdxW-1:0] NbAll = 4'd9;

   typedef enum logic [ReqTypeW-1:0] {
      REQ_READ   = 3'd0,
      REQ_UPDATE = 3'd1,
      REQ_POS    = 3'd2,
      REQ_CLEAR  = 3'd3,
      REQ_SCAN   = 3'd4
   } req_code_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ORIGIN_X  = 3'd0,
      CSR_ORIGIN_Y  = 3'd1,
      CSR_SCALE_X   = 3'd2,
      CSR_SCALE_Y   = 3'd3,
      CSR_USED_X    = 3'd4,
      CSR_USED_Y    = 3'd5,
      CSR_MODE      = 3'd6,
      CSR_NEIGHBOR  = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_QSUB,
      ST_QABS,
      ST_QMUL,
      ST_CHECK,
      ST_RD_ISSUE,
      ST_RD_DATA,
      ST_RMW,
      ST_SCAN,
      ST_SCAN_DRAIN,
      ST_DONE
   } sg_state_type;

   // Column offset of splat entry k: entry 0 is the center cell.
   function automatic logic signed [1:0] nb_dx(input logic [NbIdxW-1:0] k);
      logic signed [1:0] d;
      case (k) inside
         4'd1, 4'd4, 4'd6: d = -2'sd1;
         4'd3, 4'd5, 4'd8: d = 2'sd1;
         default:          d = 2'sd0;
      endcase
      return d;
   endfunction

   // Row offset of splat entry k.
   function automatic logic signed [1:0] nb_dy(input logic [NbIdxW-1:0] k);
      logic signed [1:0] d;
      case (k) inside
         4'd1, 4'd2, 4'd3: d = -2'sd1;
         4'd6, 4'd7, 4'd8: d = 2'sd1;
         default:          d = 2'sd0;
      endcase
      return d;
   endfunction

   // Merge a new score into a cell: empty cells take it, others keep min or max.
   function automatic logic signed [ValW-1:0] combine_val(
      input logic signed [ValW-1:0] old_v,
      input logic signed [ValW-1:0] new_v,
      input logic                   max_mode
   );
      logic signed [ValW-1:0] r;
      if (old_v == InvalidMark) begin
         r = new_v;
      end else if (max_mode) begin
         r = (new_v > old_v) ? new_v : old_v;
      end else begin
         r = (new_v < old_v) ? new_v : old_v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/score_grid_min_max_splat_top.sv @@
// ----------------------------------------------------------------------------
// Score grid with min/max combine and 3x3 splat
// A request arrives on req_* (kind in req_tuser, fields in req_tdata) and
// yields exactly one response on rsp_* (value in rsp_tdata, hit in rsp_tuser).
// Registers are written through csr_we / csr_index / csr_wdata; the user must
// write them only while idle, which the block itself does not enforce.
// All cells live in one simple dual-port memory (one read, one write a cycle,
// read data registered), so work is paced by that memory's ports.
// One request is in flight at a time; the next can be taken in the cycle
// after the response is loaded into the output register.
// Reset runs a clearing pass over all GRID_COLS*GRID_ROWS cells (16384 at the
// default size) that marks every cell empty; req_tready stays low meanwhile.
// A stalled receiver holds the response; a finished request then waits until
// the output register frees up before the next request is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "score_grid_min_max_splat_top_defines.svh"

module score_grid_min_max_splat_top #(
   parameter int GRID_COLS = sgrid_pkg::DefGridCols,
   parameter int GRID_ROWS = sgrid_pkg::DefGridRows
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // req_tdata: cell_x, cell_y, pos_x, pos_y, new_value.
   input  logic [sgrid_pkg::ReqTdataW-1:0]     req_tdata,
   // req_tuser: req_type.
   input  logic [sgrid_pkg::ReqTypeW-1:0]      req_tuser,
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // rsp_tdata: value_out.
   output logic [sgrid_pkg::ValW-1:0]          rsp_tdata,
   // rsp_tuser: hit.
   output logic                                rsp_tuser,
   // Register write port.
   input  logic                                csr_we,
   input  logic [sgrid_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [sgrid_pkg::CsrDataW-1:0]      csr_wdata
);
   import sgrid_pkg::*;

   localparam int Cxw   = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam int Ryw   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int Depth = GRID_COLS * GRID_ROWS;
   localparam int Aw    = $clog2(Depth);

   // Configuration registers.
   logic signed [PosW-1:0]   origin_x_ff, origin_y_ff;
   logic [ScaleW-1:0]        scale_x_ff, scale_y_ff;
   logic [UsedW-1:0]         used_x_ff, used_y_ff;
   logic                     mode_ff, nb_en_ff;

   // Captured request.
   logic [ReqTypeW-1:0]      type_ff, type_in;
   logic [CoordW-1:0]        cell_x_ff, cell_x_in, cell_y_ff, cell_y_in;
   logic signed [PosW-1:0]   pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [ValW-1:0]   new_val_ff, new_val_in;

   // Position quantization pipeline.
   logic signed [DiffW-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic [DiffW-1:0]         mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic                     neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [ProdW-1:0]         prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;

   // Cell walk and read-modify-write.
   logic [Cxw-1:0]           cen_x_ff, cen_x_in;
   logic [Ryw-1:0]           cen_y_ff, cen_y_in;
   logic [NbIdxW-1:0]        n_cells_ff, n_cells_in, rd_k_ff, rd_k_in;
   logic                     wr_pend_ff, wr_pend_in;
   logic [Aw-1:0]            wr_addr_ff, wr_addr_in;

   // Scan and clear.
   logic [Cxw-1:0]           sx_ff, sx_in;
   logic [Ryw-1:0]           sy_ff, sy_in;
   logic                     scan_rv_ff, scan_rv_in;
   logic signed [ValW-1:0]   scan_max_ff, scan_max_in;
   logic [Aw-1:0]            clr_addr_ff, clr_addr_in;
   logic                     clr_rsp_ff, clr_rsp_in;

   // Result and output register.
   logic signed [ValW-1:0]   res_value_ff, res_value_in;
   logic                     res_hit_ff, res_hit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ValW-1:0]          rsp_value_ff, rsp_value_in;
   logic                     rsp_hit_ff, rsp_hit_in;

   sg_state_type             state_ff, state_in;

   // Memory ports.
   logic [ValW-1:0]          cell_mem [Depth];
   logic                     mem_we, mem_re;
   logic [Aw-1:0]            mem_waddr, mem_raddr;
   logic [ValW-1:0]          mem_wdata;
   logic signed [ValW-1:0]   mem_rdata_ff;

   // Quantized coordinates and grid limits.
   logic [DiffW-1:0]         lim_x, lim_y, qx, qy;
   logic                     in_x, in_y, in_grid, interior;
   logic [Cxw-1:0]           nb_x;
   logic [Ryw-1:0]           nb_y;

   function automatic logic [Aw-1:0] cell_addr(input logic [Cxw-1:0] x,
                                               input logic [Ryw-1:0] y);
      return Aw'(y) * Aw'(GRID_COLS) + Aw'(x);
   endfunction

   // Used size saturates at the grid dimension.
   assign lim_x = (DiffW'(used_x_ff) > DiffW'(GRID_COLS)) ? DiffW'(GRID_COLS)
                                                          : DiffW'(used_x_ff);
   assign lim_y = (DiffW'(used_y_ff) > DiffW'(GRID_ROWS)) ? DiffW'(GRID_ROWS)
                                                          : DiffW'(used_y_ff);

   // Candidate cell: either the given coordinates or the quantized position.
   // A negative quantized coordinate only counts as inside when it truncated to 0.
   always_comb begin
      if (type_ff == REQ_POS) begin
         qx   = prod_x_ff[ProdW-1:ScaleW];
         qy   = prod_y_ff[ProdW-1:ScaleW];
         in_x = !(neg_x_ff && (qx != '0)) && (qx < lim_x);
         in_y = !(neg_y_ff && (qy != '0)) && (qy < lim_y);
      end else begin
         qx   = DiffW'(cell_x_ff);
         qy   = DiffW'(cell_y_ff);
         in_x = qx < lim_x;
         in_y = qy < lim_y;
      end
   end

   assign in_grid  = in_x && in_y;
   assign interior = (qx != '0) && (qx < lim_x - DiffW'(1)) &&
                     (qy != '0) && (qy < lim_y - DiffW'(1));

   // Coordinates of splat entry rd_k around the center.
   assign nb_x   = cen_x_ff + Cxw'(nb_dx(rd_k_ff));
   assign nb_y   = cen_y_ff + Ryw'(nb_dy(rd_k_ff));

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         scale_x_ff  <= '0;
         scale_y_ff  <= '0;
         used_x_ff   <= UsedW'(128);
         used_y_ff   <= UsedW'(128);
         mode_ff     <= 1'b0;
         nb_en_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_X: origin_x_ff <= csr_wdata[PosW-1:0];
            CSR_ORIGIN_Y: origin_y_ff <= csr_wdata[PosW-1:0];
            CSR_SCALE_X:  scale_x_ff  <= csr_wdata[ScaleW-1:0];
            CSR_SCALE_Y:  scale_y_ff  <= csr_wdata[ScaleW-1:0];
            CSR_USED_X:   used_x_ff   <= csr_wdata[UsedW-1:0];
            CSR_USED_Y:   used_y_ff   <= csr_wdata[UsedW-1:0];
            CSR_MODE:     mode_ff     <= csr_wdata[0];
            CSR_NEIGHBOR: nb_en_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Next state, datapath updates and memory port control.
   always_comb begin
      state_in     = state_ff;
      type_in      = type_ff;
      cell_x_in    = cell_x_ff;
      cell_y_in    = cell_y_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      new_val_in   = new_val_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      mag_x_in     = mag_x_ff;
      mag_y_in     = mag_y_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      prod_x_in    = prod_x_ff;
      prod_y_in    = prod_y_ff;
      cen_x_in     = cen_x_ff;
      cen_y_in     = cen_y_ff;
      n_cells_in   = n_cells_ff;
      rd_k_in      = rd_k_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      scan_rv_in   = 1'b0;
      scan_max_in  = scan_max_ff;
      clr_addr_in  = clr_addr_ff;
      clr_rsp_in   = clr_rsp_ff;
      res_value_in = res_value_ff;
      res_hit_in   = res_hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_hit_in   = rsp_hit_ff;
      mem_we       = 1'b0;
      mem_waddr    = wr_addr_ff;
      mem_wdata    = combine_val(mem_rdata_ff, new_val_ff, mode_ff);
      mem_re       = 1'b0;
      mem_raddr    = cell_addr(nb_x, nb_y);
      req_tready   = 1'b0;

      // Scan data returns in the cycle after each read.
      if (scan_rv_ff && (mem_rdata_ff > scan_max_ff)) begin
         scan_max_in = mem_rdata_ff;
      end

      unique case (state_ff)
         // Sweep the memory, marking every cell empty.
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = InvalidMark;
            if (clr_addr_ff == Aw'(Depth - 1)) begin
               clr_rsp_in   = 1'b0;
               res_value_in = '0;
               res_hit_in   = 1'b0;
               state_in     = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + Aw'(1);
            end
         end

         // Take a request and dispatch on its kind.
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               type_in      = req_tuser;
               cell_x_in    = req_tdata[CellXLsb +: CoordW];
               cell_y_in    = req_tdata[CellYLsb +: CoordW];
               pos_x_in     = req_tdata[PosXLsb +: PosW];
               pos_y_in     = req_tdata[PosYLsb +: PosW];
               new_val_in   = req_tdata[NewValLsb +: ValW];
               res_value_in = '0;
               res_hit_in   = 1'b0;
               case (req_tuser)
                  REQ_READ, REQ_UPDATE: state_in = ST_CHECK;
                  REQ_POS:              state_in = ST_QSUB;
                  REQ_CLEAR: begin
                     clr_addr_in = '0;
                     clr_rsp_in  = 1'b1;
                     state_in    = ST_CLEAR;
                  end
                  REQ_SCAN: begin
                     sx_in       = '0;
                     sy_in       = '0;
                     scan_max_in = '0;
                     state_in    = ((lim_x == '0) || (lim_y == '0)) ? ST_DONE : ST_SCAN;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end

         // Offset from the grid origin.
         ST_QSUB: begin
            dx_in    = DiffW'(pos_x_ff) - DiffW'(origin_x_ff);
            dy_in    = DiffW'(pos_y_ff) - DiffW'(origin_y_ff);
            state_in = ST_QABS;
         end

         // Split into sign and magnitude so scaling truncates toward zero.
         ST_QABS: begin
            neg_x_in = dx_ff[DiffW-1];
            neg_y_in = dy_ff[DiffW-1];
            mag_x_in = dx_ff[DiffW-1] ? DiffW'(-dx_ff) : DiffW'(dx_ff);
            mag_y_in = dy_ff[DiffW-1] ? DiffW'(-dy_ff) : DiffW'(dy_ff);
            state_in = ST_QMUL;
         end

         // Scale by cells per millimeter in Q0.24.
         ST_QMUL: begin
            prod_x_in = ProdW'(mag_x_ff) * ProdW'(scale_x_ff);
            prod_y_in = ProdW'(mag_y_ff) * ProdW'(scale_y_ff);
            state_in  = ST_CHECK;
         end

         // Range check and choice of the cells to touch.
         ST_CHECK: begin
            cen_x_in   = qx[Cxw-1:0];
            cen_y_in   = qy[Ryw-1:0];
            rd_k_in    = '0;
            n_cells_in = NbOne;
            res_hit_in = in_grid;
            case (type_ff)
               REQ_READ: begin
                  if (in_grid) begin
                     state_in = ST_RD_ISSUE;
                  end else begin
                     res_value_in = InvalidMark;
                     state_in     = ST_DONE;
                  end
               end
               REQ_UPDATE: state_in = in_grid ? ST_RMW : ST_DONE;
               REQ_POS: begin
                  if (nb_en_ff && interior) begin
                     n_cells_in = NbAll;
                  end
                  state_in = in_grid ? ST_RMW : ST_DONE;
               end
               default: state_in = ST_DONE;
            endcase
         end

         // Plain read of the center cell.
         ST_RD_ISSUE: begin
            mem_re   = 1'b1;
            state_in = ST_RD_DATA;
         end

         ST_RD_DATA: begin
            res_value_in = mem_rdata_ff;
            state_in     = ST_DONE;
         end

         // Read cell k while writing back cell k-1; the cells are distinct.
         ST_RMW: begin
            if (rd_k_ff < n_cells_ff) begin
               mem_re     = 1'b1;
               wr_addr_in = cell_addr(nb_x, nb_y);
               wr_pend_in = 1'b1;
               rd_k_in    = rd_k_ff + NbIdxW'(1);
            end
            if (wr_pend_ff) begin
               mem_we = 1'b1;
            end
            if ((rd_k_ff == n_cells_ff) && !wr_pend_ff) begin
               state_in = ST_DONE;
            end
         end

         // Walk the used area row by row, one read a cycle.
         ST_SCAN: begin
            mem_re     = 1'b1;
            mem_raddr  = cell_addr(sx_ff, sy_ff);
            scan_rv_in = 1'b1;
            if (DiffW'(sx_ff) == lim_x - DiffW'(1)) begin
               sx_in = '0;
               if (DiffW'(sy_ff) == lim_y - DiffW'(1)) begin
                  state_in = ST_SCAN_DRAIN;
               end else begin
                  sy_in = sy_ff + Ryw'(1);
               end
            end else begin
               sx_in = sx_ff + Cxw'(1);
            end
         end

         // The last read folds in this cycle.
         ST_SCAN_DRAIN: begin
            res_value_in = scan_max_in;
            state_in     = ST_DONE;
         end

         // Hand the result to the output register once it is free.
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_hit_in   = res_hit_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         wr_pend_ff   <= 1'b0;
         scan_rv_ff   <= 1'b0;
         clr_addr_ff  <= '0;
         clr_rsp_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         wr_pend_ff   <= wr_pend_in;
         scan_rv_ff   <= scan_rv_in;
         clr_addr_ff  <= clr_addr_in;
         clr_rsp_ff   <= clr_rsp_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      type_ff      <= type_in;
      cell_x_ff    <= cell_x_in;
      cell_y_ff    <= cell_y_in;
      pos_x_ff     <= pos_x_in;
      pos_y_ff     <= pos_y_in;
      new_val_ff   <= new_val_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      mag_x_ff     <= mag_x_in;
      mag_y_ff     <= mag_y_in;
      neg_x_ff     <= neg_x_in;
      neg_y_ff     <= neg_y_in;
      prod_x_ff    <= prod_x_in;
      prod_y_ff    <= prod_y_in;
      cen_x_ff     <= cen_x_in;
      cen_y_ff     <= cen_y_in;
      n_cells_ff   <= n_cells_in;
      rd_k_ff      <= rd_k_in;
      wr_addr_ff   <= wr_addr_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      scan_max_ff  <= scan_max_in;
      res_value_ff <= res_value_in;
      res_hit_ff   <= res_hit_in;
      rsp_value_ff <= rsp_value_in;
      rsp_hit_ff   <= rsp_hit_in;
   end

   // Cell memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= cell_mem[mem_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_hit_ff;

   // Design checks.
   `SG_ASSERT_IMPLY(a_no_rw_collision, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit the same cell")
   `SG_ASSERT_IMPLY(a_scan_no_write, (state_ff == ST_SCAN) || (state_ff == ST_SCAN_DRAIN), !mem_we, "memory written during a scan")
   `SG_ASSERT_IMPLY(a_rmw_bound, state_ff == ST_RMW, rd_k_ff <= n_cells_ff, "splat index ran past its cell count")
   `SG_ASSERT_NEXT(a_done_loads, (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready), rsp_valid_ff && (state_ff == ST_IDLE), "finished request not handed to the output")

endmodule

`default_nettype wire
